// ===== src/bawr_pkg.sv =====
// Package for the bilinear alpha-weighted resampler.
// Holds shared constants, register and opcode codes, and shared types.
// Depends on nothing.
`timescale 1ns / 1ps

package bawr_pkg;

   localparam int DEF_MAX_SRC_WIDTH  = 64;
   localparam int DEF_MAX_SRC_HEIGHT = 64;
   localparam int DEF_FRAC_BITS      = 8;

   localparam int COORD_W    = 9;
   localparam int CH_W       = 8;
   localparam int PIX_W      = 4 * CH_W;
   localparam int DIMREG_W   = 7;
   localparam int SIZE_W     = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_SIZE   = 2'd2;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [DIMREG_W-1:0] RST_SRC_WIDTH  = 7'd64;
   localparam logic [DIMREG_W-1:0] RST_SRC_HEIGHT = 7'd64;
   localparam logic [SIZE_W-1:0]   RST_OUT_SIZE   = 10'd64;

   typedef struct packed {
      logic [CH_W-1:0] a;
      logic [CH_W-1:0] r;
      logic [CH_W-1:0] g;
      logic [CH_W-1:0] b;
   } pixel_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== src/bawr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module bawr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== src/bawr_front.sv =====
// Front end: accepts requests, drops out-of-image loads, and maps sample
// coordinates to source neighbours and fractions through a pipelined divider.
// Depends on bawr_pkg.
`timescale 1ns / 1ps

module bawr_front import bawr_pkg::*; #(
   parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
   parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
   parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         in_valid,
   output logic                                         in_stall,
   input  logic                                         in_opcode,
   input  logic [COORD_W-1:0]                           in_coord_x,
   input  logic [COORD_W-1:0]                           in_coord_y,
   input  pixel_type                                    in_pixel,
   input  logic [$clog2(MAX_SRC_WIDTH+1)-1:0]           w_eff,
   input  logic [$clog2(MAX_SRC_HEIGHT+1)-1:0]          h_eff,
   input  logic [SIZE_W-1:0]                            s_eff,
   output logic                                         out_valid,
   input  logic                                         out_stall,
   output logic                                         out_sample,
   output logic [(MAX_SRC_WIDTH > 1 ? $clog2(MAX_SRC_WIDTH) : 1)-1:0]   out_x0,
   output logic [(MAX_SRC_WIDTH > 1 ? $clog2(MAX_SRC_WIDTH) : 1)-1:0]   out_x1,
   output logic [(MAX_SRC_HEIGHT > 1 ? $clog2(MAX_SRC_HEIGHT) : 1)-1:0] out_y0,
   output logic [(MAX_SRC_HEIGHT > 1 ? $clog2(MAX_SRC_HEIGHT) : 1)-1:0] out_y1,
   output logic [FRAC_BITS:0]                           out_tx,
   output logic [FRAC_BITS:0]                           out_ty,
   output pixel_type                                    out_pixel
);

   localparam int EW    = $clog2(MAX_SRC_WIDTH + 1);
   localparam int EH    = $clog2(MAX_SRC_HEIGHT + 1);
   localparam int XW    = MAX_SRC_WIDTH > 1 ? $clog2(MAX_SRC_WIDTH) : 1;
   localparam int YW    = MAX_SRC_HEIGHT > 1 ? $clog2(MAX_SRC_HEIGHT) : 1;
   localparam int EMAX  = EW > EH ? EW : EH;
   localparam int NW    = COORD_W + 2 + EMAX;
   localparam int DW    = SIZE_W + 1;
   localparam int STEPS = NW + FRAC_BITS + 1;

   logic            adv;
   logic [DW-1:0]   dvs;
   logic            in_range;
   logic [NW-1:0]   nx_in;
   logic [NW-1:0]   ny_in;

   logic            vld_ff  [0:STEPS];
   logic            smp_ff  [0:STEPS];
   logic [NW-1:0]   numx_ff [0:STEPS];
   logic [NW-1:0]   numy_ff [0:STEPS];
   logic [DW-1:0]   remx_ff [0:STEPS];
   logic [DW-1:0]   remy_ff [0:STEPS];
   logic [STEPS-1:0] qx_ff  [0:STEPS];
   logic [STEPS-1:0] qy_ff  [0:STEPS];
   logic [XW-1:0]   lx_ff   [0:STEPS];
   logic [YW-1:0]   ly_ff   [0:STEPS];
   pixel_type       pix_ff  [0:STEPS];

   assign adv      = !out_stall;
   assign in_stall = out_stall;
   assign dvs      = {s_eff, 1'b0};

   assign in_range = (16'(in_coord_x) < 16'(w_eff)) && (16'(in_coord_y) < 16'(h_eff));
   // shifted numerator (2c+1)*W + S keeps the floor non-negative
   assign nx_in = NW'({in_coord_x, 1'b1}) * NW'(w_eff) + NW'(s_eff);
   assign ny_in = NW'({in_coord_y, 1'b1}) * NW'(h_eff) + NW'(s_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid && (in_opcode == OP_SAMPLE || in_range);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         smp_ff[0]  <= (in_opcode == OP_SAMPLE);
         numx_ff[0] <= nx_in;
         numy_ff[0] <= ny_in;
         remx_ff[0] <= '0;
         remy_ff[0] <= '0;
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         lx_ff[0]   <= XW'(in_coord_x);
         ly_ff[0]   <= YW'(in_coord_y);
         pix_ff[0]  <= in_pixel;
      end
   end

   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      logic        bx;
      logic        by;
      logic [DW:0] trx;
      logic [DW:0] try_v;
      logic        gex;
      logic        gey;

      if (k <= NW) begin : g_bit
         assign bx = numx_ff[k-1][NW-k];
         assign by = numy_ff[k-1][NW-k];
      end else begin : g_zero
         assign bx = 1'b0;
         assign by = 1'b0;
      end

      assign trx   = {remx_ff[k-1], bx};
      assign try_v = {remy_ff[k-1], by};
      assign gex   = trx >= {1'b0, dvs};
      assign gey   = try_v >= {1'b0, dvs};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            smp_ff[k]  <= smp_ff[k-1];
            numx_ff[k] <= numx_ff[k-1];
            numy_ff[k] <= numy_ff[k-1];
            remx_ff[k] <= gex ? DW'(trx - {1'b0, dvs}) : DW'(trx);
            remy_ff[k] <= gey ? DW'(try_v - {1'b0, dvs}) : DW'(try_v);
            qx_ff[k]   <= {qx_ff[k-1][STEPS-2:0], gex};
            qy_ff[k]   <= {qy_ff[k-1][STEPS-2:0], gey};
            lx_ff[k]   <= lx_ff[k-1];
            ly_ff[k]   <= ly_ff[k-1];
            pix_ff[k]  <= pix_ff[k-1];
         end
      end
   end

   // clamp neighbours and round the fractions
   logic [NW-1:0]      qix;
   logic [NW-1:0]      qiy;
   logic [NW-1:0]      wm1;
   logic [NW-1:0]      hm1;
   logic [NW-1:0]      x0c;
   logic [NW-1:0]      x1c;
   logic [NW-1:0]      y0c;
   logic [NW-1:0]      y1c;
   logic [FRAC_BITS+1:0] tx_rnd;
   logic [FRAC_BITS+1:0] ty_rnd;

   assign qix = qx_ff[STEPS][STEPS-1:FRAC_BITS+1];
   assign qiy = qy_ff[STEPS][STEPS-1:FRAC_BITS+1];
   assign wm1 = NW'(w_eff) - NW'(1);
   assign hm1 = NW'(h_eff) - NW'(1);

   always_comb begin
      if (qix == '0) begin
         x0c = '0;
      end else if (qix - NW'(1) > wm1) begin
         x0c = wm1;
      end else begin
         x0c = qix - NW'(1);
      end
      if (qiy == '0) begin
         y0c = '0;
      end else if (qiy - NW'(1) > hm1) begin
         y0c = hm1;
      end else begin
         y0c = qiy - NW'(1);
      end
      x1c = (qix > wm1) ? wm1 : qix;
      y1c = (qiy > hm1) ? hm1 : qiy;
   end

   assign tx_rnd = (FRAC_BITS+2)'(qx_ff[STEPS][FRAC_BITS:0]) + (FRAC_BITS+2)'(1);
   assign ty_rnd = (FRAC_BITS+2)'(qy_ff[STEPS][FRAC_BITS:0]) + (FRAC_BITS+2)'(1);

   assign out_valid  = vld_ff[STEPS];
   assign out_sample = smp_ff[STEPS];
   assign out_x0     = smp_ff[STEPS] ? XW'(x0c) : lx_ff[STEPS];
   assign out_x1     = smp_ff[STEPS] ? XW'(x1c) : lx_ff[STEPS];
   assign out_y0     = smp_ff[STEPS] ? YW'(y0c) : ly_ff[STEPS];
   assign out_y1     = smp_ff[STEPS] ? YW'(y1c) : ly_ff[STEPS];
   assign out_tx     = tx_rnd[FRAC_BITS+1:1];
   assign out_ty     = ty_rnd[FRAC_BITS+1:1];
   assign out_pixel  = pix_ff[STEPS];

endmodule

// ===== src/bawr_queue.sv =====
// Short register FIFO between the front end and the back end.
// Depends on bawr_pkg.
`timescale 1ns / 1ps

module bawr_queue import bawr_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output q_status_type     status
);

   localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [0:DEPTH-1];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_in;
   logic [CW-1:0]    count_in;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/bawr_back.sv =====
// Back end: pixel store in four parity banks, bilinear alpha-weighted blend
// and a pipelined divider for the colour channels.
// Depends on bawr_pkg and bawr_ram.
`timescale 1ns / 1ps

module bawr_back import bawr_pkg::*; #(
   parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
   parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
   parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         in_valid,
   output logic                                         in_pop,
   input  logic                                         in_sample,
   input  logic [(MAX_SRC_WIDTH > 1 ? $clog2(MAX_SRC_WIDTH) : 1)-1:0]   in_x0,
   input  logic [(MAX_SRC_WIDTH > 1 ? $clog2(MAX_SRC_WIDTH) : 1)-1:0]   in_x1,
   input  logic [(MAX_SRC_HEIGHT > 1 ? $clog2(MAX_SRC_HEIGHT) : 1)-1:0] in_y0,
   input  logic [(MAX_SRC_HEIGHT > 1 ? $clog2(MAX_SRC_HEIGHT) : 1)-1:0] in_y1,
   input  logic [FRAC_BITS:0]                           in_tx,
   input  logic [FRAC_BITS:0]                           in_ty,
   input  pixel_type                                    in_pixel,
   output logic                                         out_valid,
   input  logic                                         out_stall,
   output logic [CH_W-1:0]                              out_alpha,
   output logic [CH_W-1:0]                              out_red,
   output logic [CH_W-1:0]                              out_green,
   output logic [CH_W-1:0]                              out_blue
);

   localparam int XW        = MAX_SRC_WIDTH > 1 ? $clog2(MAX_SRC_WIDTH) : 1;
   localparam int YW        = MAX_SRC_HEIGHT > 1 ? $clog2(MAX_SRC_HEIGHT) : 1;
   localparam int BCOLS     = (MAX_SRC_WIDTH + 1) / 2;
   localparam int BROWS     = (MAX_SRC_HEIGHT + 1) / 2;
   localparam int BDEPTH    = BCOLS * BROWS;
   localparam int AW        = BDEPTH > 1 ? $clog2(BDEPTH) : 1;
   localparam int WW        = 2 * FRAC_BITS + 1;
   localparam int WA        = WW + CH_W;
   localparam int PC        = WA + CH_W;
   localparam int AS        = WA + 2;
   localparam int CS        = PC + 2;
   localparam int RW        = CS + 1;
   localparam int QB        = CH_W + 1;
   localparam int DIV_STEPS = QB;
   localparam int AHW       = AS - 2 * FRAC_BITS + 1;
   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

   logic adv;
   logic pop;

   assign adv    = !out_valid || !out_stall;
   assign pop    = adv && in_valid;
   assign in_pop = pop;

   // ---- pixel store banks, selected by column and row parity
   logic [PIX_W-1:0] rdata [0:3];

   for (genvar bi = 0; bi < 4; bi++) begin : g_bank
      logic [XW-1:0] rcol;
      logic [YW-1:0] rrow;
      logic          wr_en;
      logic [AW-1:0] wr_addr;
      logic [AW-1:0] rd_addr;

      assign rcol    = (in_x0[0] == 1'(bi % 2)) ? in_x0 : in_x1;
      assign rrow    = (in_y0[0] == 1'(bi / 2)) ? in_y0 : in_y1;
      assign wr_en   = pop && !in_sample && (in_x0[0] == 1'(bi % 2))
                       && (in_y0[0] == 1'(bi / 2));
      assign wr_addr = AW'((32'(in_y0) >> 1) * BCOLS + (32'(in_x0) >> 1));
      assign rd_addr = AW'((32'(rrow) >> 1) * BCOLS + (32'(rcol) >> 1));

      bawr_ram #(
         .WIDTH (PIX_W),
         .DEPTH (BDEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (in_pixel),
         .rd_en   (pop && in_sample),
         .rd_addr (rd_addr),
         .rd_data (rdata[bi])
      );
   end

   // ---- stage 1: weights alongside the store read
   logic [FRAC_BITS:0] omx;
   logic [FRAC_BITS:0] omy;
   logic               vld1_ff;
   logic [WW-1:0]      wt1_ff [0:3];
   logic [1:0]         bsel1_ff [0:3];

   assign omx = ONE - in_tx;
   assign omy = ONE - in_ty;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= pop && in_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wt1_ff[0]   <= WW'(WW'(omx) * WW'(omy));
         wt1_ff[1]   <= WW'(WW'(in_tx) * WW'(omy));
         wt1_ff[2]   <= WW'(WW'(omx) * WW'(in_ty));
         wt1_ff[3]   <= WW'(WW'(in_tx) * WW'(in_ty));
         bsel1_ff[0] <= {in_y0[0], in_x0[0]};
         bsel1_ff[1] <= {in_y0[0], in_x1[0]};
         bsel1_ff[2] <= {in_y1[0], in_x0[0]};
         bsel1_ff[3] <= {in_y1[0], in_x1[0]};
      end
   end

   // ---- stage 2: weight times alpha
   logic            vld2_ff;
   logic [WA-1:0]   wa2_ff [0:3];
   logic [CH_W-1:0] col2_ff [0:3][0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld2_ff <= vld1_ff;
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_wa
      pixel_type px;
      assign px = pixel_type'(rdata[bsel1_ff[i]]);
      always_ff @(posedge clock) begin
         if (adv) begin
            wa2_ff[i]     <= WA'(wt1_ff[i]) * WA'(px.a);
            col2_ff[i][0] <= px.r;
            col2_ff[i][1] <= px.g;
            col2_ff[i][2] <= px.b;
         end
      end
   end

   // ---- stage 3: alpha-weighted colour products
   logic          vld3_ff;
   logic [WA-1:0] wa3_ff [0:3];
   logic [PC-1:0] pc3_ff [0:3][0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else if (adv) begin
         vld3_ff <= vld2_ff;
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_pc
      always_ff @(posedge clock) begin
         if (adv) begin
            wa3_ff[i] <= wa2_ff[i];
            for (int c = 0; c < 3; c++) begin
               pc3_ff[i][c] <= PC'(wa2_ff[i]) * PC'(col2_ff[i][c]);
            end
         end
      end
   end

   // ---- stage 4 (divider entry): sums
   logic          dvld_ff [0:DIV_STEPS];
   logic [AS-1:0] dden_ff [0:DIV_STEPS];
   logic [RW-1:0] drem_ff [0:DIV_STEPS][0:2];
   logic [QB-1:0] dq_ff   [0:DIV_STEPS][0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff[0] <= 1'b0;
      end else if (adv) begin
         dvld_ff[0] <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dden_ff[0] <= AS'(wa3_ff[0]) + AS'(wa3_ff[1]) + AS'(wa3_ff[2]) + AS'(wa3_ff[3]);
         for (int c = 0; c < 3; c++) begin
            drem_ff[0][c] <= {CS'(pc3_ff[0][c]) + CS'(pc3_ff[1][c])
                              + CS'(pc3_ff[2][c]) + CS'(pc3_ff[3][c]), 1'b0};
            dq_ff[0][c]   <= '0;
         end
      end
   end

   // ---- restoring division of twice the colour sum by the alpha sum
   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
      logic [RW-1:0] dsh;
      assign dsh = RW'(dden_ff[j-1]) << (DIV_STEPS - j);

      always_ff @(posedge clock) begin
         if (reset) begin
            dvld_ff[j] <= 1'b0;
         end else if (adv) begin
            dvld_ff[j] <= dvld_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dden_ff[j] <= dden_ff[j-1];
         end
      end

      for (genvar c = 0; c < 3; c++) begin : g_ch
         logic ge;
         assign ge = drem_ff[j-1][c] >= dsh;
         always_ff @(posedge clock) begin
            if (adv) begin
               drem_ff[j][c] <= ge ? drem_ff[j-1][c] - dsh : drem_ff[j-1][c];
               dq_ff[j][c]   <= {dq_ff[j-1][c][QB-2:0], ge};
            end
         end
      end
   end

   // ---- rounding and saturation into the output register
   logic [AS:0]      asum_rnd;
   logic [AHW-1:0]   ahi;
   logic [CH_W-1:0]  alpha_in;
   logic [CH_W-1:0]  col_in [0:2];

   assign asum_rnd = (AS+1)'(dden_ff[DIV_STEPS]) + ((AS+1)'(1) << (2 * FRAC_BITS - 1));
   assign ahi      = asum_rnd[AS:2*FRAC_BITS];
   assign alpha_in = (ahi > AHW'(255)) ? {CH_W{1'b1}} : CH_W'(ahi);

   for (genvar c = 0; c < 3; c++) begin : g_fin
      logic [QB:0]   rr;
      logic [QB-1:0] rq;
      assign rr = (QB+1)'(dq_ff[DIV_STEPS][c]) + (QB+1)'(1);
      assign rq = rr[QB:1];
      always_comb begin
         if (dden_ff[DIV_STEPS] == '0) begin
            col_in[c] = '0;
         end else if (rq > QB'(255)) begin
            col_in[c] = {CH_W{1'b1}};
         end else begin
            col_in[c] = CH_W'(rq);
         end
      end
   end

   logic            rsp_valid_ff;
   logic [CH_W-1:0] rsp_alpha_ff;
   logic [CH_W-1:0] rsp_red_ff;
   logic [CH_W-1:0] rsp_green_ff;
   logic [CH_W-1:0] rsp_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dvld_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_alpha_ff <= alpha_in;
         rsp_red_ff   <= col_in[0];
         rsp_green_ff <= col_in[1];
         rsp_blue_ff  <= col_in[2];
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_alpha = rsp_alpha_ff;
   assign out_red   = rsp_red_ff;
   assign out_green = rsp_green_ff;
   assign out_blue  = rsp_blue_ff;

endmodule

// ===== src/bilinear_alpha_weighted_resampler.sv =====
// Top level of the bilinear alpha-weighted resampler.
// Depends on bawr_pkg, bawr_front, bawr_queue and bawr_back.
`timescale 1ns / 1ps

// Loads ARGB pixels into a source store and samples a square output image
// from it with bilinear, alpha-weighted blending. Both kinds of request go
// through the same pipeline in order, so a sample always sees every load
// accepted before it. One request is taken per cycle when the result side
// is not stalled. The front end's coordinate divider retires one quotient
// bit per stage. A sample then passes through the queue and, in the back
// end, the store read, the products and sums, the colour divider and the
// output register. Loads produce no result and loads outside the configured
// size are dropped. The store powers up undefined and is not cleared;
// sample only pixels that were loaded. Registers may be written at any time
// the block is idle; csr_ready is always high.
module bilinear_alpha_weighted_resampler import bawr_pkg::*; #(
   parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
   parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
   parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [COORD_W-1:0]    req_coord_x,
   input  logic [COORD_W-1:0]    req_coord_y,
   input  logic [CH_W-1:0]       req_pixel_alpha,
   input  logic [CH_W-1:0]       req_pixel_red,
   input  logic [CH_W-1:0]       req_pixel_green,
   input  logic [CH_W-1:0]       req_pixel_blue,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CH_W-1:0]       rsp_out_alpha,
   output logic [CH_W-1:0]       rsp_out_red,
   output logic [CH_W-1:0]       rsp_out_green,
   output logic [CH_W-1:0]       rsp_out_blue,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int EW = $clog2(MAX_SRC_WIDTH + 1);
   localparam int EH = $clog2(MAX_SRC_HEIGHT + 1);
   localparam int XW = MAX_SRC_WIDTH > 1 ? $clog2(MAX_SRC_WIDTH) : 1;
   localparam int YW = MAX_SRC_HEIGHT > 1 ? $clog2(MAX_SRC_HEIGHT) : 1;
   localparam int TW = FRAC_BITS + 1;
   localparam int QW = 1 + 2 * XW + 2 * YW + 2 * TW + PIX_W;

   // ---- configuration registers
   logic [DIMREG_W-1:0] src_width_ff;
   logic [DIMREG_W-1:0] src_height_ff;
   logic [SIZE_W-1:0]   out_size_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= RST_SRC_WIDTH;
         src_height_ff <= RST_SRC_HEIGHT;
         out_size_ff   <= RST_OUT_SIZE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SRC_WIDTH: begin
               src_width_ff <= csr_data[DIMREG_W-1:0];
            end
            CSR_SRC_HEIGHT: begin
               src_height_ff <= csr_data[DIMREG_W-1:0];
            end
            CSR_OUT_SIZE: begin
               out_size_ff <= csr_data[SIZE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // zero acts as one, oversize clamps to the store size
   logic [EW-1:0]     w_eff;
   logic [EH-1:0]     h_eff;
   logic [SIZE_W-1:0] s_eff;

   always_comb begin
      if (src_width_ff == '0) begin
         w_eff = EW'(1);
      end else if (32'(src_width_ff) > MAX_SRC_WIDTH) begin
         w_eff = EW'(MAX_SRC_WIDTH);
      end else begin
         w_eff = EW'(src_width_ff);
      end
      if (src_height_ff == '0) begin
         h_eff = EH'(1);
      end else if (32'(src_height_ff) > MAX_SRC_HEIGHT) begin
         h_eff = EH'(MAX_SRC_HEIGHT);
      end else begin
         h_eff = EH'(src_height_ff);
      end
      s_eff = (out_size_ff == '0) ? SIZE_W'(1) : out_size_ff;
   end

   // ---- front end
   pixel_type     req_pixel;
   logic          f_valid;
   logic          f_sample;
   logic [XW-1:0] f_x0;
   logic [XW-1:0] f_x1;
   logic [YW-1:0] f_y0;
   logic [YW-1:0] f_y1;
   logic [TW-1:0] f_tx;
   logic [TW-1:0] f_ty;
   pixel_type     f_pixel;
   q_status_type  q_status;

   assign req_pixel.a = req_pixel_alpha;
   assign req_pixel.r = req_pixel_red;
   assign req_pixel.g = req_pixel_green;
   assign req_pixel.b = req_pixel_blue;

   bawr_front #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
      .FRAC_BITS      (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_opcode  (req_opcode),
      .in_coord_x (req_coord_x),
      .in_coord_y (req_coord_y),
      .in_pixel   (req_pixel),
      .w_eff      (w_eff),
      .h_eff      (h_eff),
      .s_eff      (s_eff),
      .out_valid  (f_valid),
      .out_stall  (q_status.full),
      .out_sample (f_sample),
      .out_x0     (f_x0),
      .out_x1     (f_x1),
      .out_y0     (f_y0),
      .out_y1     (f_y1),
      .out_tx     (f_tx),
      .out_ty     (f_ty),
      .out_pixel  (f_pixel)
   );

   // ---- queue between front and back
   logic [QW-1:0] q_push_data;
   logic [QW-1:0] q_pop_data;
   logic          q_push;
   logic          q_pop;

   assign q_push      = f_valid && !q_status.full;
   assign q_push_data = {f_sample, f_x0, f_x1, f_y0, f_y1, f_tx, f_ty, f_pixel};

   bawr_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   logic          b_sample;
   logic [XW-1:0] b_x0;
   logic [XW-1:0] b_x1;
   logic [YW-1:0] b_y0;
   logic [YW-1:0] b_y1;
   logic [TW-1:0] b_tx;
   logic [TW-1:0] b_ty;
   pixel_type     b_pixel;

   assign {b_sample, b_x0, b_x1, b_y0, b_y1, b_tx, b_ty, b_pixel} = q_pop_data;

   // ---- back end
   bawr_back #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
      .FRAC_BITS      (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_status.empty),
      .in_pop    (q_pop),
      .in_sample (b_sample),
      .in_x0     (b_x0),
      .in_x1     (b_x1),
      .in_y0     (b_y0),
      .in_y1     (b_y1),
      .in_tx     (b_tx),
      .in_ty     (b_ty),
      .in_pixel  (b_pixel),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_alpha (rsp_out_alpha),
      .out_red   (rsp_out_red),
      .out_green (rsp_out_green),
      .out_blue  (rsp_out_blue)
   );

endmodule

// ===== src/bawr_checker.sv =====
// Port-level checks for the bilinear alpha-weighted resampler, bound to the
// top level. Depends on bawr_pkg.
`timescale 1ns / 1ps

module bawr_checker import bawr_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [CH_W-1:0]       rsp_out_alpha,
   input logic [CH_W-1:0]       rsp_out_red,
   input logic [CH_W-1:0]       rsp_out_green,
   input logic [CH_W-1:0]       rsp_out_blue,
   input logic                  csr_valid,
   input logic                  csr_ready
);

   // no result may survive reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // queue is empty after reset, so requests are taken at once
   a_ready_after_reset: assert property (@(posedge clock) $past(reset) |-> !req_stall)
      else $error("request stalled straight after reset");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_alpha)
         && $stable(rsp_out_red) && $stable(rsp_out_green) && $stable(rsp_out_blue))
      else $error("stalled result changed");

   // a stalled request stays offered
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("stalled request withdrawn");

   // register writes are never held off
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write not ready");

endmodule

bind bilinear_alpha_weighted_resampler bawr_checker u_bawr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_alpha (rsp_out_alpha),
   .rsp_out_red   (rsp_out_red),
   .rsp_out_green (rsp_out_green),
   .rsp_out_blue  (rsp_out_blue),
   .csr_valid     (csr_valid),
   .csr_ready     (csr_ready)
);

// ===== dv/tb_bilinear_alpha_weighted_resampler.sv =====
// Self-checking testbench for the bilinear alpha-weighted resampler.
// A directed table on a one-pixel image is followed by random phases.
// Each phase sets the size registers, loads the image, then samples it.
// Depends on bawr_pkg and bilinear_alpha_weighted_resampler.
`timescale 1ns / 1ps

module tb_bilinear_alpha_weighted_resampler;
   import bawr_pkg::*;

   localparam int FRAC       = DEF_FRAC_BITS;
   localparam int MAXW       = DEF_MAX_SRC_WIDTH;
   localparam int MAXH       = DEF_MAX_SRC_HEIGHT;
   localparam int LATENCY    = 2 * (11 + $clog2(MAXW + 1)) + FRAC + 18;
   localparam int CYCLE_CAP  = 400000;
   localparam int ITEM_GOAL  = 1550;

   typedef struct {
      logic            op;
      int              x;
      int              y;
      pixel_type       px;
      bit              typed;
      pixel_type       want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_opcode = OP_LOAD;
   logic [COORD_W-1:0]    req_coord_x = '0;
   logic [COORD_W-1:0]    req_coord_y = '0;
   logic [CH_W-1:0]       req_pixel_alpha = '0;
   logic [CH_W-1:0]       req_pixel_red = '0;
   logic [CH_W-1:0]       req_pixel_green = '0;
   logic [CH_W-1:0]       req_pixel_blue = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CH_W-1:0]       rsp_out_alpha;
   logic [CH_W-1:0]       rsp_out_red;
   logic [CH_W-1:0]       rsp_out_green;
   logic [CH_W-1:0]       rsp_out_blue;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   bilinear_alpha_weighted_resampler dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   bit [PIX_W-1:0]    pix_mem [MAXW*MAXH];
   bit                pix_loaded [MAXW*MAXH];
   bit [DIMREG_W-1:0] width_reg  = RST_SRC_WIDTH;
   bit [DIMREG_W-1:0] height_reg = RST_SRC_HEIGHT;
   bit [SIZE_W-1:0]   size_reg   = RST_OUT_SIZE;

   pixel_type expected_px [$];
   int        mismatches = 0;
   int        items_sent = 0;
   int        cycles = 0;
   int        burst_left = 0;
   bit        holdoff_req = 1'b0;

   function automatic int eff_width();
      if (width_reg == 0) return 1;
      return (width_reg > MAXW) ? MAXW : int'(width_reg);
   endfunction

   function automatic int eff_height();
      if (height_reg == 0) return 1;
      return (height_reg > MAXH) ? MAXH : int'(height_reg);
   endfunction

   function automatic int eff_size();
      return (size_reg == 0) ? 1 : int'(size_reg);
   endfunction

   // source position of an output coordinate: floor index and rounded fraction
   function automatic void map_coord(input int c, input int dim, input int s,
                                     output int q, output int t);
      longint d, n, f, rem;
      d = 2 * s;
      n = longint'(2 * c + 1) * dim - s;
      f = n / d;
      if (n < 0 && f * d != n) f = f - 1;
      rem = n - f * d;
      q = int'(f);
      t = int'(((rem << (FRAC + 1)) + d) / (2 * d));
      if (t > (1 << FRAC)) t = 1 << FRAC;
   endfunction

   function automatic int clamp_idx(input int v, input int last);
      if (v < 0) return 0;
      return (v > last) ? last : v;
   endfunction

   function automatic longint unsigned blend_div(input longint unsigned num,
                                                 input longint unsigned den);
      longint unsigned r;
      r = (2 * num + den) / (2 * den);
      return (r > 255) ? 255 : r;
   endfunction

   // blend four neighbours; readable is low if any was never loaded
   function automatic void blend_sample(input int cx, input int cy,
                                        output bit readable, output pixel_type res);
      int qx, qy, tx, ty, w, h, one;
      int xs [2];
      int ys [2];
      longint unsigned wt, wa, asum, rsum, gsum, bsum, av;
      pixel_type p;
      w = eff_width();
      h = eff_height();
      one = 1 << FRAC;
      map_coord(cx, w, eff_size(), qx, tx);
      map_coord(cy, h, eff_size(), qy, ty);
      xs[0] = clamp_idx(qx, w - 1);
      xs[1] = clamp_idx(qx + 1, w - 1);
      ys[0] = clamp_idx(qy, h - 1);
      ys[1] = clamp_idx(qy + 1, h - 1);
      readable = 1'b1;
      asum = 0; rsum = 0; gsum = 0; bsum = 0;
      for (int j = 0; j < 2; j++) begin
         for (int i = 0; i < 2; i++) begin
            if (!pix_loaded[ys[j]*MAXW + xs[i]]) readable = 1'b0;
            p  = pixel_type'(pix_mem[ys[j]*MAXW + xs[i]]);
            wt = longint'(i ? tx : one - tx) * longint'(j ? ty : one - ty);
            wa = wt * p.a;
            asum += wa;
            rsum += wa * p.r;
            gsum += wa * p.g;
            bsum += wa * p.b;
         end
      end
      av = (asum + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
      res.a = (av > 255) ? 8'd255 : av[7:0];
      if (asum > 0) begin
         res.r = CH_W'(blend_div(rsum, asum));
         res.g = CH_W'(blend_div(gsum, asum));
         res.b = CH_W'(blend_div(bsum, asum));
      end else begin
         res.r = '0;
         res.g = '0;
         res.b = '0;
      end
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SRC_WIDTH:  width_reg  = value[DIMREG_W-1:0];
         CSR_SRC_HEIGHT: height_reg = value[DIMREG_W-1:0];
         CSR_OUT_SIZE:   size_reg   = value[SIZE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for the last result, then let trailing loads clear the pipe
   task automatic wait_drained();
      @(posedge clock);
      while (expected_px.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic send_request(input logic op, input int x, input int y,
                               input pixel_type px, input bit typed,
                               input pixel_type want);
      bit        readable;
      pixel_type res;
      int        gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_coord_x     <= x[COORD_W-1:0];
      req_coord_y     <= y[COORD_W-1:0];
      req_pixel_alpha <= px.a;
      req_pixel_red   <= px.r;
      req_pixel_green <= px.g;
      req_pixel_blue  <= px.b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (op == OP_LOAD) begin
         if (x < eff_width() && y < eff_height()) begin
            pix_mem[y*MAXW + x]    = px;
            pix_loaded[y*MAXW + x] = 1'b1;
         end
      end else begin
         blend_sample(x, y, readable, res);
         expected_px.push_back(typed ? want : res);
      end
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
   endtask

   function automatic pixel_type rand_px();
      return pixel_type'($urandom());
   endfunction

   // result side: stall pattern plus one long hold-off on request
   int stall_mode = 0;
   int mode_left = 0;
   int holdoff_left = 0;
   always @(negedge clock) begin
      if (holdoff_req) begin
         holdoff_req = 1'b0;
         holdoff_left = 400;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(40, 200);
      end
      mode_left--;
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= mode_left[0];
         endcase
      end
   end

   always @(posedge clock) begin
      pixel_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_out_alpha, rsp_out_red, rsp_out_green, rsp_out_blue};
         if (expected_px.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h at cycle %0d", got, cycles);
         end else begin
            want = expected_px.pop_front();
            if (got.a !== want.a || got.r !== want.r || got.g !== want.g ||
                got.b !== want.b) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch at cycle %0d: expected a%h r%h g%h b%h, got a%h r%h g%h b%h",
                           cycles, want.a, want.r, want.g, want.b,
                           got.a, got.r, got.g, got.b);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("bilinear_alpha_weighted_resampler: mismatch");
         $finish;
      end
   end

   stim_row_type rows [$];

   function automatic stim_row_type mk(input logic op, input int x, input int y,
                                       input bit [31:0] px, input bit typed,
                                       input bit [31:0] want);
      stim_row_type r;
      r.op = op; r.x = x; r.y = y; r.px = px; r.typed = typed; r.want = want;
      return r;
   endfunction

   initial begin
      int        w, h, s, ew, eh, es, x, y, phase;
      bit        readable;
      pixel_type res;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one-pixel image: every sample reads that pixel whatever the coordinate
      write_reg(CSR_SRC_WIDTH, 1);
      write_reg(CSR_SRC_HEIGHT, 1);
      write_reg(CSR_OUT_SIZE, 64);
      rows.push_back(mk(OP_LOAD,     0,   0, 32'hff123456, 0, 0));
      rows.push_back(mk(OP_SAMPLE,   0,   0, 32'h0,        1, 32'hff123456));
      rows.push_back(mk(OP_SAMPLE, 511, 511, 32'hffffffff, 1, 32'hff123456));
      rows.push_back(mk(OP_LOAD,     1,   0, 32'h00000000, 0, 0));
      rows.push_back(mk(OP_LOAD,   511, 511, 32'h00000000, 0, 0));
      rows.push_back(mk(OP_LOAD,     0, 256, 32'h00000000, 0, 0));
      rows.push_back(mk(OP_SAMPLE,   5,   7, 32'h0,        1, 32'hff123456));
      rows.push_back(mk(OP_LOAD,     0,   0, 32'h00ffffff, 0, 0));
      rows.push_back(mk(OP_SAMPLE,   0,   0, 32'h0,        1, 32'h00000000));
      rows.push_back(mk(OP_LOAD,     0,   0, 32'h01ffffff, 0, 0));
      rows.push_back(mk(OP_SAMPLE,  63,   0, 32'h0,        1, 32'h01ffffff));
      rows.push_back(mk(OP_LOAD,     0,   0, 32'h8000ff7f, 0, 0));
      rows.push_back(mk(OP_SAMPLE,   0,  64, 32'h0,        1, 32'h8000ff7f));
      rows.push_back(mk(OP_LOAD,     0,   0, 32'hffffffff, 0, 0));
      rows.push_back(mk(OP_SAMPLE, 300,   2, 32'h0,        1, 32'hffffffff));
      rows.push_back(mk(OP_LOAD,     0,   0, 32'h5aa53cc3, 0, 0));
      rows.push_back(mk(OP_SAMPLE,  17,  40, 32'h0,        0, 0));
      foreach (rows[i])
         send_request(rows[i].op, rows[i].x, rows[i].y, rows[i].px,
                      rows[i].typed, rows[i].want);
      end_burst();

      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         wait_drained();
         case ($urandom_range(0, 9))
            0: w = 0;
            1: w = 127;
            2: w = 64;
            3: w = $urandom_range(65, 127);
            default: w = $urandom_range(1, 8);
         endcase
         case ($urandom_range(0, 9))
            0: h = 0;
            1: h = 127;
            2: h = 64;
            3: h = $urandom_range(65, 127);
            default: h = $urandom_range(1, 8);
         endcase
         ew = (w == 0) ? 1 : (w > MAXW ? MAXW : w);
         eh = (h == 0) ? 1 : (h > MAXH ? MAXH : h);
         if (ew * eh > 256) h = $urandom_range(1, 4);
         case ($urandom_range(0, 9))
            0: s = 0;
            1: s = 1;
            2: s = 512;
            3: s = 1023;
            4: s = $urandom_range(1, 1023);
            default: s = $urandom_range(1, 20);
         endcase
         write_reg(CSR_SRC_WIDTH, w);
         write_reg(CSR_SRC_HEIGHT, h);
         write_reg(CSR_OUT_SIZE, s);
         ew = eff_width();
         eh = eff_height();
         es = eff_size();
         if (phase == 2) holdoff_req = 1'b1;
         phase++;

         // fill the image, then sample it with some stray loads mixed in
         for (int yy = 0; yy < eh; yy++)
            for (int xx = 0; xx < ew; xx++)
               send_request(OP_LOAD, xx, yy, rand_px(), 0, '0);
         repeat (40) begin
            if ($urandom_range(0, 9) == 0) begin
               send_request(OP_LOAD, $urandom_range(0, 511), $urandom_range(0, 511),
                            rand_px(), 0, '0);
            end else begin
               if ($urandom_range(0, 3) == 0) begin
                  x = $urandom_range(0, 511);
                  y = $urandom_range(0, 511);
               end else begin
                  x = $urandom_range(0, (es + 1 > 511) ? 511 : es + 1);
                  y = $urandom_range(0, (es + 1 > 511) ? 511 : es + 1);
               end
               blend_sample(x, y, readable, res);
               // never read a pixel that was not loaded: overwrite one instead
               if (readable)
                  send_request(OP_SAMPLE, x, y, rand_px(), 0, '0);
               else
                  send_request(OP_LOAD, $urandom_range(0, ew - 1),
                               $urandom_range(0, eh - 1), rand_px(), 0, '0);
            end
         end
         end_burst();
      end

      wait_drained();
      if (mismatches == 0 && expected_px.size() == 0)
         $display("bilinear_alpha_weighted_resampler: match");
      else
         $display("bilinear_alpha_weighted_resampler: mismatch");
      $finish;
   end

endmodule
